// ----- rtl/sor_pkg.sv -----
// Shared types and constants for the spiral order matrix reader.
`timescale 1ns / 1ps
`default_nettype none

package sor_pkg;

    // Default largest matrix side
    localparam int MAX_DIM_DEF = 8;

    // Word and register widths
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    // Walk direction around the current ring
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_we;    // store the incoming word
        logic start_walk; // set up the spiral walk, clear the counter
        logic rd_en;      // read the store at the walk position
        logic step;       // advance the walk after an output word
        logic finish;     // last word gone, return to loading
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic load_done;  // current load word completes the matrix
        logic emit_last;  // word on show is the final one
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/sor_ctrl.sv -----
// Controller state machine: loading, store read and output phases.
`timescale 1ns / 1ps
`default_nettype none

module sor_ctrl
    import sor_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_READ = 3'b010,
        ST_SHOW = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   in_acc, out_acc;

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_SHOW);
    assign in_acc   = s_tready && s_tvalid;
    assign out_acc  = m_tvalid && m_tready;

    // Drive datapath commands
    always_comb begin
        cmd            = '0;
        cmd.load_we    = in_acc;
        cmd.start_walk = in_acc && sts.load_done;
        cmd.rd_en      = (state_reg == ST_READ);
        cmd.step       = out_acc && !sts.emit_last;
        cmd.finish     = out_acc && sts.emit_last;
    end

    // Advance the phase
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc && sts.load_done) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (out_acc) state_next = sts.emit_last ? ST_LOAD : ST_READ;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sor_datapath.sv -----
// Datapath: size registers, element store, word counter and spiral walker.
`timescale 1ns / 1ps
`default_nettype none

module sor_datapath
    import sor_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [DATA_W-1:0]    in_word,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    output logic [DATA_W-1:0]         out_word,
    output logic                      out_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [CNT_W-1:0]  rows_reg, rows_next, cols_reg, cols_next;
    logic [CNT_W-1:0]  cfg_dim;
    logic [TOT_W-1:0]  count_reg, count_next;
    logic [TOT_W-1:0]  total_m1, addr_full;
    logic [IDX_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [IDX_W-1:0]  top_reg, top_next, bot_reg, bot_next;
    logic [IDX_W-1:0]  lft_reg, lft_next, rgt_reg, rgt_next;
    dir_t              dir_reg, dir_next;
    logic              cfg_hit;
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Clamp a written size into 1..MAX_DIM
    always_comb begin
        priority if (cfg_data == '0) begin
            cfg_dim = CNT_W'(1);
        end else if (cfg_data > CFG_W'(MAX_DIM)) begin
            cfg_dim = CNT_W'(MAX_DIM);
        end else begin
            cfg_dim = CNT_W'(cfg_data);
        end
    end

    assign cfg_hit = cfg_valid &&
                     ((cfg_index == REG_NUM_ROWS) || (cfg_index == REG_NUM_COLS));

    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_valid && (cfg_index == REG_NUM_ROWS)) rows_next = cfg_dim;
        if (cfg_valid && (cfg_index == REG_NUM_COLS)) cols_next = cfg_dim;
    end

    assign total_m1 = TOT_W'(TOT_W'(rows_reg) * TOT_W'(cols_reg) - TOT_W'(1));

    // Count words loaded, then words emitted
    always_comb begin
        count_next = count_reg;
        priority if (cfg_hit || cmd.start_walk || cmd.finish) begin
            count_next = '0;
        end else if (cmd.load_we || cmd.step) begin
            count_next = count_reg + TOT_W'(1);
        end
    end

    assign sts.load_done = (count_reg == total_m1);
    assign sts.emit_last = (count_reg == total_m1);

    // Walk the rings: move along an edge, turn and shrink a bound at its end
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        top_next = top_reg;
        bot_next = bot_reg;
        lft_next = lft_reg;
        rgt_next = rgt_reg;
        dir_next = dir_reg;
        if (cmd.start_walk) begin
            row_next = '0;
            col_next = '0;
            top_next = '0;
            lft_next = '0;
            bot_next = IDX_W'(rows_reg - CNT_W'(1));
            rgt_next = IDX_W'(cols_reg - CNT_W'(1));
            dir_next = DIR_RIGHT;
        end else if (cmd.step) begin
            unique case (dir_reg)
                DIR_RIGHT: begin
                    if (col_reg == rgt_reg) begin
                        top_next = top_reg + IDX_W'(1);
                        row_next = row_reg + IDX_W'(1);
                        dir_next = DIR_DOWN;
                    end else begin
                        col_next = col_reg + IDX_W'(1);
                    end
                end
                DIR_DOWN: begin
                    if (row_reg == bot_reg) begin
                        rgt_next = rgt_reg - IDX_W'(1);
                        col_next = col_reg - IDX_W'(1);
                        dir_next = DIR_LEFT;
                    end else begin
                        row_next = row_reg + IDX_W'(1);
                    end
                end
                DIR_LEFT: begin
                    if (col_reg == lft_reg) begin
                        bot_next = bot_reg - IDX_W'(1);
                        row_next = row_reg - IDX_W'(1);
                        dir_next = DIR_UP;
                    end else begin
                        col_next = col_reg - IDX_W'(1);
                    end
                end
                DIR_UP: begin
                    if (row_reg == top_reg) begin
                        lft_next = lft_reg + IDX_W'(1);
                        col_next = col_reg + IDX_W'(1);
                        dir_next = DIR_RIGHT;
                    end else begin
                        row_next = row_reg - IDX_W'(1);
                    end
                end
                default: dir_next = DIR_RIGHT;
            endcase
        end
    end

    // Row-major store address of the walk position
    assign addr_full = TOT_W'(TOT_W'(row_reg) * TOT_W'(cols_reg) + TOT_W'(col_reg));

    // Element store: write while loading, registered read while emitting
    always_ff @(posedge aclk) begin
        if (cmd.load_we) mem[count_reg[ADDR_W-1:0]] <= in_word;
        if (cmd.rd_en) rd_data_reg <= mem[addr_full[ADDR_W-1:0]];
    end

    assign out_word = rd_data_reg;
    assign out_last = sts.emit_last;

    // Walker position and bounds
    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        col_reg <= col_next;
        top_reg <= top_next;
        bot_reg <= bot_next;
        lft_reg <= lft_next;
        rgt_reg <= rgt_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= CNT_W'(MAX_DIM);
            cols_reg  <= CNT_W'(MAX_DIM);
            count_reg <= '0;
            dir_reg   <= DIR_RIGHT;
        end else begin
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            count_reg <= count_next;
            dir_reg   <= dir_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/spiral_order_matrix_reader.sv -----
// Top level of the spiral order matrix reader.
//
// Load a num_rows x num_cols matrix of signed 32-bit words in row-major order, one
// word per cycle on the s_ stream; when the final word is taken the block stops
// accepting input and emits every word in clockwise spiral order on the m_ stream,
// with m_tlast on the final word, then returns to loading. Each output word passes
// through a registered read of the element store and is then held in the output
// register until the sink takes it. Sizes 0 act as 1 and sizes above MAX_DIM act
// as MAX_DIM; a size write clears a partly loaded matrix.
`timescale 1ns / 1ps
`default_nettype none

module spiral_order_matrix_reader
    import sor_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // Input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_W-1:0]    s_tdata,  // [31:0] element_value
    // Output stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DATA_W-1:0]         m_tdata,  // [31:0] out_value
    output logic                      m_tlast   // out_last
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    sor_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sor_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_word  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/sor_checker.sv -----
// Port-level checker for the spiral order matrix reader, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sor_checker
    import sor_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic [DATA_W-1:0] s_tdata,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic              m_tlast
);

    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while output words are shown");

    // A stalled input word holds until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
        else $error("input word changed before it was taken");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output word changed under stall");

    // After the final word, loading resumes at once
    a_last_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("no return to loading after the final word");

    // Between two spiral words comes a store read, with neither stream active
    a_read_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid && !s_tready))
        else $error("spiral word shown without a store read");

endmodule

bind spiral_order_matrix_reader sor_checker u_sor_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- test/tb_spiral_order_matrix_reader.sv -----
// Self-checking testbench for the spiral order matrix reader.
`timescale 1ns / 1ps

module tb_spiral_order_matrix_reader;
    import sor_pkg::*;

    localparam int MAX_DIM        = MAX_DIM_DEF;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 12;

    // Indexes past the register list; writes to these must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } spiral_word_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;   // [31:0] element_value
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;          // [31:0] out_value
    logic                 m_tlast;          // out_last

    // Words waiting to be offered, and spiral words still owed by the block
    logic [DATA_W-1:0] element_q[$];
    spiral_word_t      spiral_q[$];

    // Mirror of the block's matrix store and size registers
    logic [DATA_W-1:0] matrix_mem [MAX_DIM*MAX_DIM];
    int                load_cnt  = 0;
    logic [CFG_W-1:0]  rows_reg  = 4'd8;
    logic [CFG_W-1:0]  cols_reg  = 4'd8;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic holdoff_req   = 1'b0;
    int   hold_left     = 0;
    int   error_count   = 0;
    int   cycle_count   = 0;

    spiral_order_matrix_reader i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Size 0 acts as 1, sizes above the maximum act as the maximum
    function automatic int eff_size(input int v);
        if (v < 1) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // Store one word; on the final word of the matrix queue the whole spiral
    function automatic void load_element(input logic [DATA_W-1:0] v);
        int   r, c, top, bot, lft, rgt, i, k;
        int   order[$];
        dir_t dir;
        r = eff_size(int'(rows_reg));
        c = eff_size(int'(cols_reg));
        if (load_cnt < MAX_DIM*MAX_DIM) matrix_mem[load_cnt] = v;
        load_cnt++;
        if (load_cnt < r*c) return;
        top = 0;
        bot = r - 1;
        lft = 0;
        rgt = c - 1;
        dir = DIR_RIGHT;
        // walk one side per pass, turning clockwise, until the bounds cross
        while (top <= bot && lft <= rgt) begin
            case (dir)
                DIR_RIGHT: begin
                    for (i = lft; i <= rgt; i++) order.push_back(top*c + i);
                    top++;
                    dir = DIR_DOWN;
                end
                DIR_DOWN: begin
                    for (i = top; i <= bot; i++) order.push_back(i*c + rgt);
                    rgt--;
                    dir = DIR_LEFT;
                end
                DIR_LEFT: begin
                    for (i = rgt; i >= lft; i--) order.push_back(bot*c + i);
                    bot--;
                    dir = DIR_UP;
                end
                default: begin
                    for (i = bot; i >= top; i--) order.push_back(i*c + lft);
                    lft++;
                    dir = DIR_RIGHT;
                end
            endcase
        end
        for (k = 0; k < order.size(); k++)
            spiral_q.push_back('{value: matrix_mem[order[k]], last: (k == order.size() - 1)});
        load_cnt = 0;
    endfunction

    // Mostly random words, with the signed extremes mixed in
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Input driver: hold a word until taken, then offer the next or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) load_element(s_tdata);
            if (element_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata  <= element_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: check each word taken against the oldest owed one
    always @(posedge aclk) begin
        spiral_word_t exp_word;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (spiral_q.size() == 0) begin
                    $error("unexpected output word: out_value %h out_last %b", m_tdata, m_tlast);
                    error_count++;
                end else begin
                    exp_word = spiral_q.pop_front();
                    if (m_tdata !== exp_word.value) begin
                        $error("out_value: expected %h actual %h", exp_word.value, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== exp_word.last) begin
                        $error("out_last: expected %b actual %b", exp_word.last, m_tlast);
                        error_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long sink hold-off, counted down here
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (holdoff_req && hold_left == 0) begin
            hold_left <= HOLDOFF_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Guard against a hung block
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Write one register and mirror it once the write is taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_NUM_ROWS) begin
            rows_reg = val;
            load_cnt = 0;
        end else if (idx == REG_NUM_COLS) begin
            cols_reg = val;
            load_cnt = 0;
        end
        cfg_valid <= 1'b0;
    endtask

    // Wait until every word is sent and every spiral word is back, then settle
    task automatic wait_drained();
        while (element_q.size() != 0 || s_tvalid || spiral_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random matrices of mostly small sizes; some left partial for the next write to drop
    task automatic run_phase(input int send_pct, input int recv_pct, input int budget);
        int queued, rows_val, cols_val, cells, words, extra;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queued = 0;
        while (queued < budget) begin
            rows_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            cols_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_W'($urandom_range(0, 15)));
            write_reg(REG_NUM_ROWS, rows_val[CFG_W-1:0]);
            write_reg(REG_NUM_COLS, cols_val[CFG_W-1:0]);
            cells = eff_size(rows_val) * eff_size(cols_val);
            words = cells * $urandom_range(1, 2);
            extra = (cells > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, cells - 1) : 0;
            @(negedge aclk);
            repeat (words + extra) element_q.push_back(pick_value());
            queued += words + extra;
            wait_drained();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Single element at both signed extremes; spare indexes must not disturb sizes
        write_reg(REG_SPARE_A, 4'd3);
        write_reg(REG_SPARE_B, 4'd5);
        write_reg(REG_NUM_ROWS, 4'd1);
        write_reg(REG_NUM_COLS, 4'd1);
        @(negedge aclk);
        element_q.push_back(32'h8000_0000);
        element_q.push_back(32'h7FFF_FFFF);
        wait_drained();

        // Zero rows and oversize columns: one row of the maximum width
        write_reg(REG_NUM_ROWS, 4'd0);
        write_reg(REG_NUM_COLS, 4'd15);
        @(negedge aclk);
        element_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h8000_0001, 32'h7FFF_FFFE, 32'h1234_5678};
        wait_drained();

        // Oversize rows and zero columns: one column of the maximum height
        write_reg(REG_NUM_ROWS, 4'd9);
        write_reg(REG_NUM_COLS, 4'd0);
        @(negedge aclk);
        repeat (8) element_q.push_back(pick_value());
        wait_drained();

        // Partly loaded 2x3 dropped by a size write, then a full 2x2
        write_reg(REG_NUM_ROWS, 4'd2);
        write_reg(REG_NUM_COLS, 4'd3);
        @(negedge aclk);
        repeat (4) element_q.push_back(pick_value());
        wait_drained();
        write_reg(REG_NUM_COLS, 4'd2);
        @(negedge aclk);
        repeat (4) element_q.push_back(pick_value());
        wait_drained();

        // Full-size matrix at full rate
        write_reg(REG_NUM_ROWS, 4'd8);
        write_reg(REG_NUM_COLS, 4'd8);
        @(negedge aclk);
        repeat (64) element_q.push_back(pick_value());
        wait_drained();

        // Sink holds off while three matrices queue up behind it
        write_reg(REG_NUM_ROWS, 4'd3);
        write_reg(REG_NUM_COLS, 4'd4);
        @(posedge aclk);
        holdoff_req <= 1'b1;
        @(posedge aclk);
        holdoff_req <= 1'b0;
        @(negedge aclk);
        repeat (36) element_q.push_back(pick_value());
        wait_drained();

        run_phase(0, 0, 15);
        run_phase(80, 0, 15);
        run_phase(0, 80, 15);
        run_phase(18, 18, 15);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
